FILE: src/lcmpa_pkg.sv
// lcmpa_pkg: shared types and constants of the led color morph / pulse animator
// used by lcmpa_color_mem and led_color_morph_pulse_animator_core
package lcmpa_pkg;

    localparam int LIGHTS  = 8;
    localparam int IDX_W   = 3;
    localparam int COLOR_W = 32;
    localparam int FIELDS  = 4;
    localparam int ENTRY_W = FIELDS * COLOR_W;

    // entry field order: start, end, reset, current
    typedef enum logic [1:0] {
        KIND_START_COLOR = 2'd0,
        KIND_END_COLOR   = 2'd1,
        KIND_RESET_COLOR = 2'd2,
        KIND_TICK        = 2'd3
    } kind_t;

    localparam logic [1:0] FIELD_START   = 2'd0;
    localparam logic [1:0] FIELD_END     = 2'd1;
    localparam logic [1:0] FIELD_RESET   = 2'd2;
    localparam logic [1:0] FIELD_CURRENT = 2'd3;

    localparam logic [2:0] REG_EFFECT_MODE = 3'd0;
    localparam logic [2:0] REG_TRANSITION  = 3'd1;
    localparam logic [2:0] REG_START_HOLD  = 3'd2;
    localparam logic [2:0] REG_END_HOLD    = 3'd3;
    localparam logic [2:0] REG_REPEAT      = 3'd4;

    localparam logic [1:0] MODE_MORPH = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;

    typedef enum logic [2:0] {
        SEL_START,
        SEL_END,
        SEL_RESET,
        SEL_UP,
        SEL_DOWN
    } sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_TOTAL,
        ST_CHECK,
        ST_MOD,
        ST_PLAN,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [FIELDS-1:0] wr_mask;
        logic [COLOR_W-1:0] wr_data;
    } mem_req_t;

endpackage

FILE: src/lcmpa_color_mem.sv
// lcmpa_color_mem: per-light color store, one entry holds start, end, reset, current
// depends on lcmpa_pkg; registered read, entries read as zero until written
module lcmpa_color_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcmpa_pkg::mem_req_t           req,
    output logic [lcmpa_pkg::ENTRY_W-1:0] rd_data
);

    logic [lcmpa_pkg::ENTRY_W-1:0] mem [lcmpa_pkg::LIGHTS];
    logic [lcmpa_pkg::LIGHTS-1:0]  valid_reg;
    logic [lcmpa_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    // a first write to an entry also clears its other fields
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            for (int k = 0; k < lcmpa_pkg::FIELDS; k++)
            begin
                if (req.wr_mask[k])
                    mem[req.wr_addr][k*lcmpa_pkg::COLOR_W +: lcmpa_pkg::COLOR_W] <= req.wr_data;
                else if (!valid_reg[req.wr_addr])
                    mem[req.wr_addr][k*lcmpa_pkg::COLOR_W +: lcmpa_pkg::COLOR_W] <= '0;
            end
        end
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: src/led_color_morph_pulse_animator_core.sv
// led_color_morph_pulse_animator_core: top level of the color fade and pulse engine
// depends on lcmpa_pkg and lcmpa_color_mem
// a single-light color write is taken while idle and busy stays low; a broadcast write
// keeps busy high in the fill state, one memory write per light
// a tick runs total and check, then the phase modulo in pulse mode, then plan; per
// light it runs read, load, the radix-4 divider when fading, and write-back
// results come one per light, each a single-cycle strobe; the receiver cannot stall
// reset clears control state and makes every stored color read as zero
module led_color_morph_pulse_animator_core (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [2:0]  light_index,
    input  logic        write_all,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  brightness,
    input  logic [31:0] time_now,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // results
    output logic        result_valid,
    output logic [2:0]  out_light,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_brightness,
    output logic        light_changed,
    output logic        any_changed,
    output logic        finished,
    output logic        last
);

    localparam logic [2:0] LAST_LIGHT = 3'(lcmpa_pkg::LIGHTS - 1);

    // configuration registers
    logic [1:0]  mode_reg;
    logic [15:0] trans_reg;
    logic [15:0] shold_reg;
    logic [15:0] ehold_reg;
    logic [7:0]  repeat_reg;

    // animation state
    logic        armed_reg;
    logic        recorded_reg;
    logic [31:0] start_time_reg;

    lcmpa_pkg::state_t state_reg, state_next;

    // tick working registers
    logic [31:0] elapsed_reg;
    logic [17:0] period_reg;
    logic [25:0] total_reg;
    logic [31:0] mdvd_reg;
    logic [17:0] mrem_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  idx_reg;
    lcmpa_pkg::sel_t sel_reg;
    logic [15:0] num_reg;
    logic        ends_reg;
    logic        any_reg;

    // broadcast write
    logic [31:0] fill_color_reg;
    logic [3:0]  fill_mask_reg;

    // fade lanes, one per color component
    logic        up_reg  [4];
    logic [15:0] rem_reg [4];
    logic [7:0]  low_reg [4];
    logic [7:0]  quo_reg [4];

    // result registers
    logic        result_valid_reg;
    logic [2:0]  out_light_reg;
    logic [31:0] out_color_reg;
    logic        changed_reg;
    logic        any_out_reg;
    logic        finished_reg;
    logic        last_reg;

    lcmpa_pkg::mem_req_t           mem_req;
    logic [lcmpa_pkg::ENTRY_W-1:0] entry;

    lcmpa_color_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (entry)
    );

    logic        accept;
    logic        is_tick;
    logic [31:0] color_in;
    logic [3:0]  kind_mask;

    assign accept    = start && !busy;
    assign is_tick   = (kind == lcmpa_pkg::KIND_TICK);
    assign color_in  = {brightness, blue, green, red};
    assign kind_mask = 4'b0001 << kind;

    // entry fields
    logic [31:0] f_start, f_end, f_reset, f_cur;
    assign f_start = entry[0*32 +: 32];
    assign f_end   = entry[1*32 +: 32];
    assign f_reset = entry[2*32 +: 32];
    assign f_cur   = entry[3*32 +: 32];

    // phase modulo step, restoring, one bit per cycle
    logic [18:0] mshift;
    logic        mge;
    assign mshift = {mrem_reg, mdvd_reg[31]};
    assign mge    = (mshift >= {1'b0, period_reg});

    // pulse plan: segment bounds inside one period
    logic [15:0] seg_a;
    logic [16:0] seg_b;
    logic [17:0] seg_c;
    logic [18:0] seg_d;
    logic [17:0] phase;
    lcmpa_pkg::sel_t plan_sel;
    logic [15:0] plan_num;
    logic        plan_ends;

    assign phase = mrem_reg;
    assign seg_a = {1'b0, shold_reg[15:1]};
    assign seg_b = {1'b0, seg_a} + {1'b0, trans_reg};
    assign seg_c = {1'b0, seg_b} + {2'b00, ehold_reg};
    assign seg_d = {1'b0, seg_c} + {3'b000, trans_reg};

    always_comb
    begin
        plan_sel  = lcmpa_pkg::SEL_END;
        plan_num  = '0;
        plan_ends = 1'b1;
        if (mode_reg == lcmpa_pkg::MODE_MORPH)
        begin
            if (elapsed_reg < {16'b0, trans_reg})
            begin
                plan_sel  = lcmpa_pkg::SEL_UP;
                plan_num  = elapsed_reg[15:0];
                plan_ends = 1'b0;
            end
        end
        else if (mode_reg == lcmpa_pkg::MODE_PULSE)
        begin
            if (elapsed_reg >= {6'b0, total_reg})
                plan_sel = lcmpa_pkg::SEL_RESET;
            else
            begin
                plan_ends = 1'b0;
                priority if (phase < {2'b00, seg_a})
                    plan_sel = lcmpa_pkg::SEL_START;
                else if (phase < {1'b0, seg_b})
                begin
                    plan_sel = lcmpa_pkg::SEL_UP;
                    plan_num = 16'(phase - {2'b00, seg_a});
                end
                else if (phase < seg_c)
                    plan_sel = lcmpa_pkg::SEL_END;
                else if ({1'b0, phase} < seg_d)
                begin
                    plan_sel = lcmpa_pkg::SEL_DOWN;
                    plan_num = 16'(phase - seg_c);
                end
                else
                    plan_sel = lcmpa_pkg::SEL_START;
            end
        end
    end

    // per-lane fade setup, two quotient bits per divider cycle and final color
    logic [7:0]  ls [4];
    logic [7:0]  le [4];
    logic [7:0]  gap_lane [4];
    logic [16:0] r1 [4];
    logic [16:0] r2 [4];
    logic [15:0] r1n [4];
    logic        q1 [4];
    logic        q2 [4];
    logic [15:0] rem_step [4];
    logic [7:0]  nc_lane [4];
    logic [31:0] new_color;
    logic        is_fade;

    assign is_fade = (sel_reg == lcmpa_pkg::SEL_UP) || (sel_reg == lcmpa_pkg::SEL_DOWN);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ls[k]  = f_start[k*8 +: 8];
            le[k]  = f_end[k*8 +: 8];
            gap_lane[k] = (le[k] >= ls[k]) ? le[k] - ls[k] : ls[k] - le[k];
            r1[k]  = {rem_reg[k], low_reg[k][7]};
            q1[k]  = (r1[k] >= {1'b0, trans_reg});
            r1n[k] = q1[k] ? 16'(r1[k] - {1'b0, trans_reg}) : r1[k][15:0];
            r2[k]  = {r1n[k], low_reg[k][6]};
            q2[k]  = (r2[k] >= {1'b0, trans_reg});
            rem_step[k] = q2[k] ? 16'(r2[k] - {1'b0, trans_reg}) : r2[k][15:0];
            if (sel_reg == lcmpa_pkg::SEL_UP)
                nc_lane[k] = up_reg[k] ? ls[k] + quo_reg[k] : ls[k] - quo_reg[k];
            else
                nc_lane[k] = up_reg[k] ? le[k] - quo_reg[k] : le[k] + quo_reg[k];
        end
    end

    always_comb
    begin
        unique case (sel_reg)
            lcmpa_pkg::SEL_START: new_color = f_start;
            lcmpa_pkg::SEL_END:   new_color = f_end;
            lcmpa_pkg::SEL_RESET: new_color = f_reset;
            default:              new_color = {nc_lane[3], nc_lane[2], nc_lane[1], nc_lane[0]};
        endcase
    end

    logic changed_now;
    assign changed_now = (new_color != f_cur);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcmpa_pkg::ST_IDLE:
            begin
                if (accept && !is_tick && write_all)
                    state_next = lcmpa_pkg::ST_FILL;
                else if (accept && is_tick && armed_reg)
                    state_next = lcmpa_pkg::ST_TOTAL;
            end
            lcmpa_pkg::ST_FILL:
                if (idx_reg == LAST_LIGHT)
                    state_next = lcmpa_pkg::ST_IDLE;
            lcmpa_pkg::ST_TOTAL:
                state_next = lcmpa_pkg::ST_CHECK;
            lcmpa_pkg::ST_CHECK:
                if (mode_reg == lcmpa_pkg::MODE_PULSE && elapsed_reg < {6'b0, total_reg})
                    state_next = lcmpa_pkg::ST_MOD;
                else
                    state_next = lcmpa_pkg::ST_PLAN;
            lcmpa_pkg::ST_MOD:
                if (cnt_reg == 5'd31)
                    state_next = lcmpa_pkg::ST_PLAN;
            lcmpa_pkg::ST_PLAN:
                state_next = lcmpa_pkg::ST_READ;
            lcmpa_pkg::ST_READ:
                state_next = lcmpa_pkg::ST_LOAD;
            lcmpa_pkg::ST_LOAD:
                state_next = is_fade ? lcmpa_pkg::ST_DIV : lcmpa_pkg::ST_WB;
            lcmpa_pkg::ST_DIV:
                if (cnt_reg[1:0] == 2'd3)
                    state_next = lcmpa_pkg::ST_WB;
            lcmpa_pkg::ST_WB:
                state_next = (idx_reg == LAST_LIGHT) ? lcmpa_pkg::ST_IDLE : lcmpa_pkg::ST_READ;
            default:
                state_next = lcmpa_pkg::ST_IDLE;
        endcase
    end

    // outputs: busy and memory port
    // the current-color write of one light never meets the read of the same light
    always_comb
    begin
        busy    = (state_reg != lcmpa_pkg::ST_IDLE);
        mem_req = '0;
        unique case (state_reg)
            lcmpa_pkg::ST_IDLE:
                if (accept && !is_tick && !write_all && ({1'b0, light_index} < 4'(lcmpa_pkg::LIGHTS)))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = light_index;
                    mem_req.wr_mask = kind_mask;
                    mem_req.wr_data = color_in;
                end
            lcmpa_pkg::ST_FILL:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_mask = fill_mask_reg;
                mem_req.wr_data = fill_color_reg;
            end
            lcmpa_pkg::ST_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
            end
            lcmpa_pkg::ST_WB:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_mask = 4'b0001 << lcmpa_pkg::FIELD_CURRENT;
                mem_req.wr_data = new_color;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lcmpa_pkg::ST_IDLE;
            mode_reg         <= '0;
            trans_reg        <= '0;
            shold_reg        <= '0;
            ehold_reg        <= '0;
            repeat_reg       <= 8'd1;
            armed_reg        <= 1'b0;
            recorded_reg     <= 1'b0;
            start_time_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == lcmpa_pkg::ST_WB);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcmpa_pkg::REG_EFFECT_MODE: mode_reg   <= cfg_wdata[1:0];
                    lcmpa_pkg::REG_TRANSITION:  trans_reg  <= cfg_wdata;
                    lcmpa_pkg::REG_START_HOLD:  shold_reg  <= cfg_wdata;
                    lcmpa_pkg::REG_END_HOLD:    ehold_reg  <= cfg_wdata;
                    lcmpa_pkg::REG_REPEAT:      repeat_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
                if (cfg_index <= lcmpa_pkg::REG_REPEAT)
                    armed_reg <= 1'b1;
            end
            if (accept && !is_tick)
                armed_reg <= 1'b1;
            // first tick taken while armed pins the animation start time
            if (accept && is_tick && armed_reg && !recorded_reg)
            begin
                recorded_reg   <= 1'b1;
                start_time_reg <= time_now;
            end
            if (state_reg == lcmpa_pkg::ST_WB && idx_reg == LAST_LIGHT && ends_reg)
                armed_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lcmpa_pkg::ST_IDLE:
            begin
                idx_reg        <= '0;
                fill_color_reg <= color_in;
                fill_mask_reg  <= kind_mask;
                elapsed_reg    <= recorded_reg ? time_now - start_time_reg : '0;
                period_reg     <= {1'b0, trans_reg, 1'b0} + {2'b00, shold_reg}
                                  + {2'b00, ehold_reg};
            end
            lcmpa_pkg::ST_FILL:
                idx_reg <= idx_reg + 3'd1;
            lcmpa_pkg::ST_TOTAL:
                total_reg <= {8'b0, period_reg} * {18'b0, repeat_reg};
            lcmpa_pkg::ST_CHECK:
            begin
                mdvd_reg <= elapsed_reg;
                mrem_reg <= '0;
                cnt_reg  <= '0;
            end
            lcmpa_pkg::ST_MOD:
            begin
                mdvd_reg <= {mdvd_reg[30:0], 1'b0};
                mrem_reg <= mge ? 18'(mshift - {1'b0, period_reg}) : mshift[17:0];
                cnt_reg  <= cnt_reg + 5'd1;
            end
            lcmpa_pkg::ST_PLAN:
            begin
                sel_reg  <= plan_sel;
                num_reg  <= plan_num;
                ends_reg <= plan_ends;
                any_reg  <= 1'b0;
            end
            lcmpa_pkg::ST_LOAD:
            begin
                cnt_reg <= '0;
                for (int k = 0; k < 4; k++)
                begin
                    up_reg[k]  <= (le[k] >= ls[k]);
                    quo_reg[k] <= '0;
                end
            end
            lcmpa_pkg::ST_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                // gap*num has its high bits below T, so the quotient fits 8 bits
                for (int k = 0; k < 4; k++)
                begin
                    rem_reg[k] <= rem_step[k];
                    low_reg[k] <= {low_reg[k][5:0], 2'b00};
                    quo_reg[k] <= {quo_reg[k][5:0], q1[k], q2[k]};
                end
            end
            lcmpa_pkg::ST_WB:
            begin
                idx_reg       <= idx_reg + 3'd1;
                any_reg       <= any_reg | changed_now;
                out_light_reg <= idx_reg;
                out_color_reg <= new_color;
                changed_reg   <= changed_now;
                last_reg      <= (idx_reg == LAST_LIGHT);
                any_out_reg   <= (idx_reg == LAST_LIGHT) && (any_reg || changed_now);
                finished_reg  <= ends_reg;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
        // product register feeding the divider lanes
        if (state_reg == lcmpa_pkg::ST_LOAD)
        begin
            for (int k = 0; k < 4; k++)
            begin
                {rem_reg[k], low_reg[k]} <= {16'b0, gap_lane[k]} * {8'b0, num_reg};
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign out_light      = out_light_reg;
    assign out_red        = out_color_reg[7:0];
    assign out_green      = out_color_reg[15:8];
    assign out_blue       = out_color_reg[23:16];
    assign out_brightness = out_color_reg[31:24];
    assign light_changed  = changed_reg;
    assign any_changed    = any_out_reg;
    assign finished       = finished_reg;
    assign last           = last_reg;

endmodule
